// ----- hw/rtl/tms_pkg.sv -----
package tms_pkg;

    localparam int TABU_DEPTH = 64;
    localparam int IDX_W      = 10;
    localparam int SCORE_W    = 32;
    localparam int CNT_W      = $clog2(TABU_DEPTH + 1);
    localparam int CFG_W      = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int RAND_W     = 6;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TENURE_BASE      = 2'd0,
        CFG_TENURE_EXTRA_MAX = 2'd1,
        CFG_ASPIRATION_EN    = 2'd2
    } cfg_sel_t;

    typedef struct packed {
        logic shift;
        logic probe;
    } cell_ctl_t;

endpackage

// ----- hw/rtl/tms_cell.sv -----
module tms_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  tms_pkg::cell_ctl_t          ctl,
    input  logic                        live,
    input  logic [tms_pkg::IDX_W-1:0]   shift_in,
    input  logic [tms_pkg::IDX_W-1:0]   probe_index,
    output logic [tms_pkg::IDX_W-1:0]   shift_out,
    output logic                        hit
);
    import tms_pkg::*;

    logic [IDX_W-1:0] entry_reg;
    logic             hit_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.shift)
        begin
            entry_reg <= shift_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else if (ctl.probe)
        begin
            hit_reg <= live && (entry_reg == probe_index);
        end
    end

    assign shift_out = entry_reg;
    assign hit       = hit_reg;

endmodule

// ----- hw/rtl/tabu_move_selector.sv -----
// Tabu move selector with aspiration. Candidate moves stream in one item per
// cycle while in_ready is high; after an item marked last of round, input is held
// off while its result is formed and the best move is pushed into the tabu list. Each item
// passes two stages: the probe stage compares the candidate against every entry
// of the tabu list at once (one cell per entry, newest first) and the select
// stage resolves tabu status, aspiration and the running best. The tabu list is
// a row of 64 cells that shifts by one on each push; the fill count bounds which
// cells take part. A result waits in an output register, and input items keep
// flowing while it waits unless a new last-of-round item reaches the select
// stage before the previous result is taken.
module tabu_move_selector (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [tms_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [tms_pkg::CFG_W-1:0]            cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [tms_pkg::IDX_W-1:0]            candidate_index,
    input  logic signed [tms_pkg::SCORE_W-1:0]   candidate_score,
    input  logic                                 first_of_round,
    input  logic                                 last_of_round,
    input  logic [tms_pkg::RAND_W-1:0]           random_extra,
    input  logic signed [tms_pkg::SCORE_W-1:0]   aspiration_level,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 move_found,
    output logic [tms_pkg::IDX_W-1:0]            chosen_index,
    output logic signed [tms_pkg::SCORE_W-1:0]   chosen_score,
    output logic [tms_pkg::CNT_W-1:0]            tabu_fill
);
    import tms_pkg::*;

    logic [CFG_W-1:0]          tenure_base_reg;
    logic [CFG_W-1:0]          tenure_extra_max_reg;
    logic                      aspiration_en_reg;

    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic [CNT_W-1:0]          active_tenure_reg;
    logic signed [SCORE_W-1:0] round_asp_reg;

    logic                      best_valid_reg;
    logic [IDX_W-1:0]          best_index_reg;
    logic signed [SCORE_W-1:0] best_score_reg;

    logic                      b_valid_reg;
    logic                      b_first_reg;
    logic                      b_last_reg;
    logic                      b_asp_gt_reg;
    logic [IDX_W-1:0]          b_index_reg;
    logic signed [SCORE_W-1:0] b_score_reg;

    logic                      out_valid_reg;
    logic                      out_found_reg;
    logic [IDX_W-1:0]          out_index_reg;
    logic signed [SCORE_W-1:0] out_score_reg;
    logic [CNT_W-1:0]          out_fill_reg;

    logic                      in_fire;
    logic                      b_fire;
    logic [CFG_W-1:0]          extra_a;
    logic [CFG_W:0]            tenure_sum_a;
    logic [CNT_W-1:0]          tenure_a;
    logic [CNT_W-1:0]          tenure_eff_a;
    logic signed [SCORE_W-1:0] level_eff_a;
    logic [CNT_W-1:0]          span_a;

    logic [TABU_DEPTH-1:0]     live;
    logic [TABU_DEPTH-1:0]     hits;
    logic [IDX_W-1:0]          chain [TABU_DEPTH+1];
    cell_ctl_t                 cell_ctl;

    logic                      tabu_b;
    logic                      eligible_b;
    logic                      cur_valid_b;
    logic signed [SCORE_W-1:0] cur_score_b;
    logic                      take_b;
    logic                      new_valid_b;
    logic [IDX_W-1:0]          new_index_b;
    logic signed [SCORE_W-1:0] new_score_b;
    logic                      push_b;
    logic [CFG_W:0]            cap_sum;
    logic [CNT_W-1:0]          cap;
    logic [CNT_W-1:0]          kept;

    // handshake
    assign in_ready = !(b_valid_reg && b_last_reg);
    assign in_fire  = in_valid && in_ready;
    assign b_fire   = b_valid_reg && (!b_last_reg || !out_valid_reg || out_ready);

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tenure_base_reg      <= CFG_W'(8);
            tenure_extra_max_reg <= '0;
            aspiration_en_reg    <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_TENURE_BASE:      tenure_base_reg      <= cfg_data;
                CFG_TENURE_EXTRA_MAX: tenure_extra_max_reg <= cfg_data;
                CFG_ASPIRATION_EN:    aspiration_en_reg    <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // probe stage: round parameters and span
    always_comb
    begin
        if (tenure_extra_max_reg == '0)
        begin
            extra_a = '0;
        end
        else if (CFG_W'(random_extra) < (tenure_extra_max_reg - CFG_W'(1)))
        begin
            extra_a = CFG_W'(random_extra);
        end
        else
        begin
            extra_a = tenure_extra_max_reg - CFG_W'(1);
        end
        tenure_sum_a = {1'b0, tenure_base_reg} + {1'b0, extra_a};
        tenure_a     = (tenure_sum_a > (CFG_W+1)'(TABU_DEPTH)) ? CNT_W'(TABU_DEPTH)
                                                              : tenure_sum_a[CNT_W-1:0];
        tenure_eff_a = first_of_round ? tenure_a : active_tenure_reg;
        level_eff_a  = first_of_round ? aspiration_level : round_asp_reg;
        span_a       = (tenure_eff_a < count_reg) ? tenure_eff_a : count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_tenure_reg <= '0;
            round_asp_reg     <= '0;
        end
        else if (in_fire && first_of_round)
        begin
            active_tenure_reg <= tenure_a;
            round_asp_reg     <= aspiration_level;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            b_valid_reg <= 1'b1;
        end
        else if (b_fire)
        begin
            b_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            b_first_reg  <= first_of_round;
            b_last_reg   <= last_of_round;
            b_index_reg  <= candidate_index;
            b_score_reg  <= candidate_score;
            b_asp_gt_reg <= candidate_score > level_eff_a;
        end
    end

    // tabu list
    assign cell_ctl.shift = push_b;
    assign cell_ctl.probe = in_fire;
    assign chain[0]       = new_index_b;

    for (genvar k = 0; k < TABU_DEPTH; k++)
    begin : g_cell
        assign live[k] = CNT_W'(k) < span_a;

        tms_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (cell_ctl),
            .live        (live[k]),
            .shift_in    (chain[k]),
            .probe_index (candidate_index),
            .shift_out   (chain[k+1]),
            .hit         (hits[k])
        );
    end

    // select stage
    always_comb
    begin
        tabu_b      = |hits;
        eligible_b  = !tabu_b || (aspiration_en_reg && b_asp_gt_reg);
        cur_valid_b = b_first_reg ? 1'b0 : best_valid_reg;
        cur_score_b = b_first_reg ? '0 : best_score_reg;
        take_b      = eligible_b && (!cur_valid_b || (b_score_reg > cur_score_b));
        new_valid_b = cur_valid_b || take_b;
        new_index_b = take_b ? b_index_reg : (b_first_reg ? '0 : best_index_reg);
        new_score_b = take_b ? b_score_reg : cur_score_b;
        push_b      = b_fire && b_last_reg && new_valid_b;

        cap_sum = {1'b0, tenure_base_reg} + {1'b0, tenure_extra_max_reg};
        cap     = (cap_sum > (CFG_W+1)'(TABU_DEPTH)) ? CNT_W'(TABU_DEPTH)
                                                     : cap_sum[CNT_W-1:0];
        kept    = (count_reg >= cap) ? (cap - CNT_W'(1)) : count_reg;
        if (!new_valid_b)
        begin
            count_next = count_reg;
        end
        else if (cap == '0)
        begin
            count_next = '0;
        end
        else
        begin
            count_next = kept + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_valid_reg <= 1'b0;
            best_index_reg <= '0;
            best_score_reg <= '0;
            count_reg      <= '0;
        end
        else if (b_fire)
        begin
            best_valid_reg <= new_valid_b;
            best_index_reg <= new_index_b;
            best_score_reg <= new_score_b;
            if (b_last_reg)
            begin
                count_reg <= count_next;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (b_fire && b_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_fire && b_last_reg)
        begin
            out_found_reg <= new_valid_b;
            out_index_reg <= new_valid_b ? new_index_b : '0;
            out_score_reg <= new_valid_b ? new_score_b : '0;
            out_fill_reg  <= count_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign move_found   = out_found_reg;
    assign chosen_index = out_index_reg;
    assign chosen_score = out_score_reg;
    assign tabu_fill    = out_fill_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABU_DEPTH))
        else $error("tabu fill count above depth");

    a_result_follows_last: assert property (@(posedge clk) disable iff (!rst_n)
        (b_fire && b_last_reg) |=> out_valid_reg)
        else $error("last item did not produce a result");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !$past(out_valid_reg)) |-> $past(b_valid_reg && b_last_reg))
        else $error("result without a last item");

    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_found_reg) |-> (out_index_reg == '0 && out_score_reg == '0))
        else $error("empty result carries a move");

endmodule

// ----- tb/tb.sv -----
module tb;
    import tms_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 10;
    localparam int PHASE_ITEMS    = 80;

    typedef struct packed {
        logic [IDX_W-1:0]   idx;
        logic [SCORE_W-1:0] score;
        logic               first;
        logic               last;
        logic [RAND_W-1:0]  rnd;
        logic [SCORE_W-1:0] lvl;
    } move_item_t;

    typedef struct packed {
        logic               found;
        logic [IDX_W-1:0]   index;
        logic [SCORE_W-1:0] score;
        logic [CNT_W-1:0]   fill;
    } move_result_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]      cfg_index = '0;
    logic [CFG_W-1:0]          cfg_data = '0;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic [IDX_W-1:0]          candidate_index = '0;
    logic signed [SCORE_W-1:0] candidate_score = '0;
    logic                      first_of_round = 1'b0;
    logic                      last_of_round = 1'b0;
    logic [RAND_W-1:0]         random_extra = '0;
    logic signed [SCORE_W-1:0] aspiration_level = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic                      move_found;
    logic [IDX_W-1:0]          chosen_index;
    logic signed [SCORE_W-1:0] chosen_score;
    logic [CNT_W-1:0]          tabu_fill;

    tabu_move_selector u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .candidate_index  (candidate_index),
        .candidate_score  (candidate_score),
        .first_of_round   (first_of_round),
        .last_of_round    (last_of_round),
        .random_extra     (random_extra),
        .aspiration_level (aspiration_level),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .move_found       (move_found),
        .chosen_index     (chosen_index),
        .chosen_score     (chosen_score),
        .tabu_fill        (tabu_fill)
    );

    always #5 clk = ~clk;

    move_item_t   pending_moves[$];
    move_result_t expected_choices[$];
    int           total_queued = 0;
    int           accepted_cnt = 0;
    int           results_seen = 0;
    int           errors = 0;
    int           idle_pct = 20;
    int           stall_cycles = 0;
    int           idle_watch = 0;
    bit           long_hold_done = 1'b0;
    logic         in_acc = 1'b0;

    // predictor state
    int                 cfg_base = 8;
    int                 cfg_extra_max = 0;
    bit                 cfg_asp = 1'b0;
    logic [IDX_W-1:0]   recent_moves[$];
    int                 act_tenure = 0;
    logic [SCORE_W-1:0] round_level = '0;
    bit                 best_found = 1'b0;
    logic [IDX_W-1:0]   best_idx = '0;
    logic [SCORE_W-1:0] best_val = '0;

    function automatic bit select_move(input move_item_t it, output move_result_t res);
        int  extra;
        int  t;
        int  span;
        int  cap;
        bit  tabu;
        bit  eligible;
        res = '0;
        if (it.first)
        begin
            extra = 0;
            if (cfg_extra_max > 0)
                extra = (int'(it.rnd) < cfg_extra_max - 1) ? int'(it.rnd) : cfg_extra_max - 1;
            t = cfg_base + extra;
            act_tenure = (t > TABU_DEPTH) ? TABU_DEPTH : t;
            round_level = it.lvl;
            best_found = 1'b0;
            best_idx = '0;
            best_val = '0;
        end
        tabu = 1'b0;
        span = (act_tenure < recent_moves.size()) ? act_tenure : recent_moves.size();
        for (int k = 0; k < span; k++)
        begin
            if (recent_moves[recent_moves.size() - 1 - k] == it.idx)
                tabu = 1'b1;
        end
        eligible = !tabu || (cfg_asp && ($signed(it.score) > $signed(round_level)));
        if (eligible && (!best_found || ($signed(it.score) > $signed(best_val))))
        begin
            best_found = 1'b1;
            best_idx = it.idx;
            best_val = it.score;
        end
        if (!it.last)
            return 1'b0;
        if (best_found)
        begin
            cap = cfg_base + cfg_extra_max;
            if (cap > TABU_DEPTH)
                cap = TABU_DEPTH;
            while (recent_moves.size() > 0 && recent_moves.size() >= cap)
                recent_moves.delete(0);
            if (cap > 0)
                recent_moves.insert(recent_moves.size(), best_idx);
        end
        res.found = best_found;
        res.index = best_found ? best_idx : '0;
        res.score = best_found ? best_val : '0;
        res.fill  = CNT_W'(recent_moves.size());
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH at %0t: %s got %0d expected %0d", $time, what, got, want);
        errors++;
    endtask

    always @(negedge clk)
    begin : drive_block
        move_item_t nxt;
        if (!in_valid || in_acc)
        begin
            if (pending_moves.size() != 0 && $urandom_range(99) >= idle_pct)
            begin
                nxt = pending_moves[0];
                pending_moves.delete(0);
                in_valid <= 1'b1;
                candidate_index <= nxt.idx;
                candidate_score <= nxt.score;
                first_of_round <= nxt.first;
                last_of_round <= nxt.last;
                random_extra <= nxt.rnd;
                aspiration_level <= nxt.lvl;
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin : accept_block
        if (stall_cycles > 0)
        begin
            stall_cycles--;
            out_ready <= 1'b0;
        end
        else if (!long_hold_done && results_seen >= 60 && pending_moves.size() > 20)
        begin
            long_hold_done = 1'b1;
            stall_cycles = 150;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= idle_pct);
    end

    always @(posedge clk)
    begin : check_block
        move_item_t   it;
        move_result_t want;
        move_result_t pred;
        in_acc <= in_valid && in_ready && rst_n;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (expected_choices.size() == 0)
                    report_mismatch("result with nothing pending, index", chosen_index, 0);
                else
                begin
                    want = expected_choices[0];
                    expected_choices.delete(0);
                    if (move_found !== want.found)
                        report_mismatch("move_found", move_found, want.found);
                    if (chosen_index !== want.index)
                        report_mismatch("chosen_index", chosen_index, want.index);
                    if (chosen_score !== $signed(want.score))
                        report_mismatch("chosen_score", chosen_score, $signed(want.score));
                    if (tabu_fill !== want.fill)
                        report_mismatch("tabu_fill", tabu_fill, want.fill);
                end
            end
            if (in_valid && in_ready)
            begin
                accepted_cnt++;
                it.idx = candidate_index;
                it.score = candidate_score;
                it.first = first_of_round;
                it.last = last_of_round;
                it.rnd = random_extra;
                it.lvl = aspiration_level;
                if (select_move(it, pred))
                    expected_choices.insert(expected_choices.size(), pred);
            end
            if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_write)
                idle_watch = 0;
            else
                idle_watch++;
            if (idle_watch >= WATCHDOG_LIMIT)
            begin
                $display("tabu_move_selector verification failed");
                $finish;
            end
        end
    end

    task automatic add_item(input int idx, input int score, input int first, input int last,
                            input int rnd, input int lvl);
        move_item_t it;
        it.idx = IDX_W'(idx);
        it.score = score;
        it.first = first[0];
        it.last = last[0];
        it.rnd = RAND_W'(rnd);
        it.lvl = lvl;
        pending_moves.insert(pending_moves.size(), it);
        total_queued++;
    endtask

    task automatic write_reg(input cfg_sel_t sel, input int val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= sel;
        cfg_data <= val[CFG_W-1:0];
    endtask

    task automatic set_config(input int base, input int extra_max, input int asp);
        write_reg(CFG_TENURE_BASE, base);
        write_reg(CFG_TENURE_EXTRA_MAX, extra_max);
        write_reg(CFG_ASPIRATION_EN, asp);
        @(negedge clk);
        cfg_write <= 1'b0;
        cfg_base = base;
        cfg_extra_max = extra_max;
        cfg_asp = (asp != 0);
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (accepted_cnt != total_queued || expected_choices.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    function automatic logic [SCORE_W-1:0] rand_score();
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2, 3, 4: return 32'($signed($urandom_range(8)) - 4);
            default: return $urandom;
        endcase
    endfunction

    function automatic int rand_idx();
        if ($urandom_range(3) == 0)
            return $urandom_range(1023);
        return $urandom_range(11);
    endfunction

    function automatic int rand_tenure();
        case ($urandom_range(3))
            0: return 0;
            1: return TABU_DEPTH;
            default: return $urandom_range(TABU_DEPTH);
        endcase
    endfunction

    initial
    begin : stimulus_block
        int n;
        int len;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: item before any round opens, tabu rejects, equal scores
        add_item(5, 0, 0, 1, 0, 0);
        add_item(5, 100, 1, 0, 63, 32'h7fff_ffff);
        add_item(1023, 32'h8000_0000, 0, 0, 0, 0);
        add_item(0, 32'h7fff_ffff, 0, 0, 0, 0);
        add_item(7, 32'h7fff_ffff, 0, 1, 0, 0);
        add_item(0, 32'h1234, 1, 1, 21, 32'h8000_0000);
        add_item(1023, 32'h8000_0000, 1, 1, 42, 0);
        wait_drained();

        // aspiration: above the level wins, equal to it does not
        set_config(2, 3, 1);
        add_item(1023, -4, 1, 0, 63, -5);
        add_item(0, -5, 0, 0, 0, 0);
        add_item(5, -6, 0, 0, 0, 0);
        add_item(0, 32'h7fff_ffff, 0, 1, 0, 0);
        add_item(512, 0, 1, 1, 0, 32'h7fff_ffff);
        wait_drained();

        set_config(TABU_DEPTH, TABU_DEPTH, 0);
        add_item(341, 1, 1, 0, 63, 0);
        add_item(682, 1, 0, 1, 0, 0);
        wait_drained();

        // zero capacity empties the list
        set_config(0, 0, 1);
        add_item(341, 5, 1, 1, 0, -1);
        wait_drained();

        set_config(1, 0, 0);
        add_item(9, 3, 1, 1, 7, 0);
        add_item(9, 3, 1, 1, 7, 0);
        add_item(10, 3, 1, 1, 7, 0);
        wait_drained();

        for (int p = 0; p < 8; p++)
        begin
            if (p == 0)
                set_config(TABU_DEPTH, 0, 1);
            else if (p == 1)
                set_config(0, TABU_DEPTH, 1);
            else
                set_config(rand_tenure(), rand_tenure(), int'($urandom_range(2) != 0));
            idle_pct = (p == 2) ? 0 : 20;
            n = 0;
            while (n < PHASE_ITEMS)
            begin
                if ($urandom_range(9) == 0)
                begin
                    add_item(rand_idx(), rand_score(), $urandom_range(1), $urandom_range(1),
                             $urandom_range(63), rand_score());
                    n++;
                end
                else
                begin
                    len = ($urandom_range(3) == 0) ? $urandom_range(1, 12) : $urandom_range(1, 5);
                    for (int j = 0; j < len; j++)
                        add_item(rand_idx(), rand_score(), int'(j == 0), int'(j == len - 1),
                                 $urandom_range(63), rand_score());
                    n += len;
                end
            end
            add_item(rand_idx(), rand_score(), 0, 1, $urandom_range(63), rand_score());
            wait_drained();
        end

        if (errors == 0)
            $display("tabu_move_selector verification clean");
        else
            $display("tabu_move_selector verification failed");
        $finish;
    end

endmodule
